>>> src/zrle_pkg.sv
// ----------------------------------------------------------------------------
// zrle_pkg
// Shared types and constants for the zero run-length encoder.
// ----------------------------------------------------------------------------
package zrle_pkg;

	localparam int unsigned RUN_W   = 16;
	localparam int unsigned WORD_W  = 32;
	localparam int unsigned BYTE_W  = 8;
	localparam int unsigned POS_W   = 4;

	// Marker characters.
	localparam logic [BYTE_W-1:0] MARK_C0 = 8'h24; // '$'
	localparam logic [BYTE_W-1:0] MARK_C1 = 8'h40; // '@'
	localparam logic [BYTE_W-1:0] MARK_C2 = 8'h23; // '#'
	localparam logic [BYTE_W-1:0] MARK_C3 = 8'h68; // 'h'

	// Positions in the longest byte sequence one item can cause:
	// four marker characters, run length low and high, then four word bytes.
	localparam logic [POS_W-1:0] POS_MARK0  = 4'd0;
	localparam logic [POS_W-1:0] POS_MARK1  = 4'd1;
	localparam logic [POS_W-1:0] POS_MARK2  = 4'd2;
	localparam logic [POS_W-1:0] POS_MARK3  = 4'd3;
	localparam logic [POS_W-1:0] POS_LEN_LO = 4'd4;
	localparam logic [POS_W-1:0] POS_LEN_HI = 4'd5;
	localparam logic [POS_W-1:0] POS_WORD0  = 4'd6;
	localparam logic [POS_W-1:0] POS_WORD1  = 4'd7;
	localparam logic [POS_W-1:0] POS_WORD2  = 4'd8;
	localparam logic [POS_W-1:0] POS_WORD3  = 4'd9;

	// What one accepted item has to emit.
	typedef struct packed {
		logic              has_marker;
		logic [RUN_W-1:0]  run_len;
		logic              has_word;
		logic [WORD_W-1:0] word;
		logic              stream_end;
	} plan_t;

endpackage

>>> src/zero_run_length_encoder_unit.sv
// ----------------------------------------------------------------------------
// zero_run_length_encoder_unit
// Zero run-length encoder from 32-bit coefficient words to a byte stream.
// ----------------------------------------------------------------------------
//  Channel  Dir  Handshake            Contents
//  s_*      in   s_tvalid/s_tready    coeff_bits in tdata, stream_end in tlast
//  m_*      out  m_tvalid/m_tready    out_byte in tdata, item_last in tuser,
//                                     stream_last in tlast
//  cfg_*    in   cfg_we               rle_enable in cfg_wdata
//
// One byte leaves per cycle from the output register unless stalled: a nonzero word
// gives four bytes, a closed run adds six for its marker, and a zero word that only
// extends a run gives none. An accepted plan is registered in plan_s1, then plan_q,
// then its first byte in byte_q; the next plan is taken as the last byte leaves. Reset
// clears the run count, sets RLE mode and empties both stages. A stall on m_tready
// holds the output byte and backs up to s_tready once the plan stage is full.
// ----------------------------------------------------------------------------
module zero_run_length_encoder_unit #(
	parameter int unsigned RUN_MAX = 65535
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,  // [31:0] coeff_bits
	input  logic        s_tlast,  // stream_end
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,  // [7:0] out_byte
	output logic        m_tlast,  // stream_last
	output logic [0:0]  m_tuser   // [0] item_last
);
	import zrle_pkg::*;

	plan_t plan_s1;
	logic  plan_valid_s1;
	logic  plan_take;
	logic  item_last;

	zrle_front #(
		.RUN_MAX(RUN_MAX)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.in_valid     (s_tvalid),
		.in_ready     (s_tready),
		.in_word      (s_tdata),
		.in_end       (s_tlast),
		.plan_s1      (plan_s1),
		.plan_valid_s1(plan_valid_s1),
		.plan_take    (plan_take)
	);

	zrle_serial u_serial (
		.clk            (clk),
		.arst_n         (arst_n),
		.plan_s1        (plan_s1),
		.plan_valid_s1  (plan_valid_s1),
		.plan_take      (plan_take),
		.out_valid      (m_tvalid),
		.out_ready      (m_tready),
		.out_byte       (m_tdata),
		.out_item_last  (item_last),
		.out_stream_last(m_tlast)
	);

	assign m_tuser[0] = item_last;

endmodule

>>> src/zrle_front.sv
// ----------------------------------------------------------------------------
// zrle_front
// Input stage: keeps the zero run count and the mode register, and turns each
// accepted word into a registered emission plan.
// ----------------------------------------------------------------------------
module zrle_front #(
	parameter int unsigned RUN_MAX = 65535
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic                         cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [zrle_pkg::WORD_W-1:0]  in_word,
	input  logic                         in_end,
	output zrle_pkg::plan_t              plan_s1,
	output logic                         plan_valid_s1,
	input  logic                         plan_take
);
	import zrle_pkg::*;

	localparam logic [RUN_W-1:0] RUN_MAX_C = RUN_W'(RUN_MAX);

	logic             rle_enable_q;
	logic [RUN_W-1:0] run_count_q;
	logic [RUN_W-1:0] run_count_d;
	logic [RUN_W-1:0] run_inc;
	logic             is_zero;
	logic             accept;
	plan_t            plan_d;

	assign is_zero  = (in_word[WORD_W-2:0] == '0);
	// The count never exceeds RUN_MAX - 1 between items, so this cannot wrap.
	assign run_inc  = run_count_q + RUN_W'(1);
	assign in_ready = !plan_valid_s1 || plan_take;
	assign accept   = in_valid && in_ready;

	always_comb begin
		plan_d.has_marker = 1'b0;
		plan_d.run_len    = run_count_q;
		plan_d.has_word   = 1'b1;
		plan_d.word       = in_word;
		plan_d.stream_end = in_end;
		run_count_d       = run_count_q;
		if (!rle_enable_q || !is_zero) begin
			// An open run is closed by its marker before the word goes out.
			if (run_count_q != '0) begin
				plan_d.has_marker = 1'b1;
			end
			run_count_d = '0;
		end else begin
			plan_d.has_word = 1'b0;
			if (run_inc >= RUN_MAX_C) begin
				plan_d.has_marker = 1'b1;
				plan_d.run_len    = RUN_MAX_C;
				run_count_d       = '0;
			end else if (in_end) begin
				plan_d.has_marker = 1'b1;
				plan_d.run_len    = run_inc;
				run_count_d       = '0;
			end else begin
				run_count_d = run_inc;
			end
		end
		if (in_end) begin
			run_count_d = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rle_enable_q  <= 1'b1;
			run_count_q   <= '0;
			plan_valid_s1 <= 1'b0;
		end else begin
			if (cfg_we) begin
				rle_enable_q <= cfg_wdata;
			end
			if (accept) begin
				run_count_q <= run_count_d;
				// Items that emit nothing do not occupy the stage.
				plan_valid_s1 <= plan_d.has_marker || plan_d.has_word;
			end else if (plan_take) begin
				plan_valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			plan_s1 <= plan_d;
		end
	end

endmodule

>>> src/zrle_serial.sv
// ----------------------------------------------------------------------------
// zrle_serial
// Byte serializer: unless stalled, moves one plan byte per cycle into byte_q.
// ----------------------------------------------------------------------------
module zrle_serial (
	input  logic                         clk,
	input  logic                         arst_n,
	input  zrle_pkg::plan_t              plan_s1,
	input  logic                         plan_valid_s1,
	output logic                         plan_take,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [zrle_pkg::BYTE_W-1:0]  out_byte,
	output logic                         out_item_last,
	output logic                         out_stream_last
);
	import zrle_pkg::*;

	logic              busy_q;
	logic [POS_W-1:0]  pos_q;
	plan_t             plan_q;
	logic              out_valid_q;
	logic [BYTE_W-1:0] byte_q;
	logic              item_last_q;
	logic              stream_last_q;
	logic [POS_W-1:0]  stop_pos;
	logic              at_last;
	logic              advance;
	logic [BYTE_W-1:0] byte_sel;

	assign stop_pos  = plan_q.has_word ? POS_WORD3 : POS_LEN_HI;
	assign at_last   = (pos_q == stop_pos);
	assign advance   = busy_q && (!out_valid_q || out_ready);
	assign plan_take = plan_valid_s1 && (!busy_q || (advance && at_last));

	always_comb begin
		unique case (pos_q)
			POS_MARK0:  byte_sel = MARK_C0;
			POS_MARK1:  byte_sel = MARK_C1;
			POS_MARK2:  byte_sel = MARK_C2;
			POS_MARK3:  byte_sel = MARK_C3;
			POS_LEN_LO: byte_sel = plan_q.run_len[7:0];
			POS_LEN_HI: byte_sel = plan_q.run_len[15:8];
			POS_WORD0:  byte_sel = plan_q.word[7:0];
			POS_WORD1:  byte_sel = plan_q.word[15:8];
			POS_WORD2:  byte_sel = plan_q.word[23:16];
			POS_WORD3:  byte_sel = plan_q.word[31:24];
			default:    byte_sel = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			pos_q         <= POS_MARK0;
			out_valid_q   <= 1'b0;
			item_last_q   <= 1'b0;
			stream_last_q <= 1'b0;
		end else begin
			if (advance) begin
				out_valid_q   <= 1'b1;
				item_last_q   <= at_last;
				stream_last_q <= at_last && plan_q.stream_end;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (plan_take) begin
				busy_q <= 1'b1;
				// Without a marker the walk starts at the first word byte.
				pos_q  <= plan_s1.has_marker ? POS_MARK0 : POS_WORD0;
			end else if (advance) begin
				if (at_last) begin
					busy_q <= 1'b0;
				end else begin
					pos_q <= pos_q + POS_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (plan_take) begin
			plan_q <= plan_s1;
		end
		if (advance) begin
			byte_q <= byte_sel;
		end
	end

	assign out_valid       = out_valid_q;
	assign out_byte        = byte_q;
	assign out_item_last   = item_last_q;
	assign out_stream_last = stream_last_q;

endmodule

>>> src/zrle_checker.sv
// ----------------------------------------------------------------------------
// zrle_checker
// Port-level checks for the zero run-length encoder, bound to the top level.
// ----------------------------------------------------------------------------
module zrle_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       m_tvalid,
	input logic       m_tready,
	input logic [7:0] m_tdata,
	input logic       m_tlast,
	input logic [0:0] m_tuser
);

	// The end of the stream is always the last byte of its item.
	a_stream_last_is_item_last: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && m_tlast) |-> m_tuser[0])
		else $error("stream end byte without item end");

	// No output is presented in the cycle after reset was seen held.
	a_quiet_in_reset: assert property (@(posedge clk)
		!arst_n |=> !m_tvalid)
		else $error("output valid during reset");

	// A stalled byte holds its value and flags.
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && !m_tready) |=>
		(m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser)))
		else $error("output changed while stalled");

endmodule

bind zero_run_length_encoder_unit zrle_checker u_zrle_checker (
	.clk     (clk),
	.arst_n  (arst_n),
	.m_tvalid(m_tvalid),
	.m_tready(m_tready),
	.m_tdata (m_tdata),
	.m_tlast (m_tlast),
	.m_tuser (m_tuser)
);

>>> dv/zero_run_length_encoder_unit_test.sv
// ----------------------------------------------------------------------------
// zero_run_length_encoder_unit_test
// Self-checking bench for the zero run-length encoder. Coefficient words are
// streamed in with random gaps while the byte output is drained with random
// stalls and one long hold-off. A scoreboard predicts every byte, including
// both end flags, and compares each output byte with the oldest prediction.
// Directed items cover zero signs, NaN, stream ends and raw mode with an open
// run; random phases alternate the two modes.
// ----------------------------------------------------------------------------
module zero_run_length_encoder_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import zrle_pkg::*;

	localparam int          FULL_RUN     = 65535;
	localparam int          DRAIN_CYCLES = 24;
	localparam int          HOLD_CYCLES  = 250;
	localparam int          CYCLE_LIMIT  = 1000000;
	localparam int          PHASE_ITEMS  = 52;
	localparam bit          MODE_RAW     = 1'b0;
	localparam bit          MODE_RLE     = 1'b1;
	localparam logic [31:0] POS_ZERO     = 32'h0000_0000;
	localparam logic [31:0] NEG_ZERO     = 32'h8000_0000;

	typedef struct packed {
		logic [7:0] data;
		logic       item_last;
		logic       stream_last;
	} coded_byte_t;

	class zrle_byte_scoreboard;
		bit          rle_mode;
		int          zero_run;
		coded_byte_t expected_bytes[$];
		int unsigned errors;

		function new();
			rle_mode = MODE_RLE;
			zero_run = 0;
			errors   = 0;
		endfunction

		function void set_mode(bit mode);
			rle_mode = mode;
		endfunction

		function int pending();
			return expected_bytes.size();
		endfunction

		function void push_byte(logic [7:0] b);
			coded_byte_t cb;
			cb.data        = b;
			cb.item_last   = 1'b0;
			cb.stream_last = 1'b0;
			expected_bytes.push_back(cb);
		endfunction

		function void push_marker(int len);
			logic [15:0] run_bits;
			run_bits = len[15:0];
			push_byte(MARK_C0);
			push_byte(MARK_C1);
			push_byte(MARK_C2);
			push_byte(MARK_C3);
			push_byte(run_bits[7:0]);
			push_byte(run_bits[15:8]);
			zero_run = 0;
		endfunction

		function void push_word(logic [31:0] w);
			push_byte(w[7:0]);
			push_byte(w[15:8]);
			push_byte(w[23:16]);
			push_byte(w[31:24]);
		endfunction

		// Predicts the bytes one accepted coefficient causes.
		function void note_coeff(logic [31:0] w, logic last);
			int first_new;
			first_new = expected_bytes.size();
			if (rle_mode == MODE_RAW) begin
				if (zero_run != 0)
					push_marker(zero_run);
				push_word(w);
			end else if (w[30:0] == 31'd0) begin
				zero_run = zero_run + 1;
				if (zero_run >= FULL_RUN)
					push_marker(FULL_RUN);
				else if (last)
					push_marker(zero_run);
			end else begin
				if (zero_run != 0)
					push_marker(zero_run);
				push_word(w);
			end
			if (last)
				zero_run = 0;
			if (expected_bytes.size() > first_new) begin
				expected_bytes[expected_bytes.size()-1].item_last   = 1'b1;
				expected_bytes[expected_bytes.size()-1].stream_last = last;
			end
		endfunction

		function void check_byte(logic [7:0] d, logic il, logic sl);
			coded_byte_t exp_b;
			if (expected_bytes.size() == 0) begin
				$display("%0t: unexpected byte %h item_last %b stream_last %b",
					$time, d, il, sl);
				errors++;
				return;
			end
			exp_b = expected_bytes.pop_front();
			if (d !== exp_b.data || il !== exp_b.item_last || sl !== exp_b.stream_last) begin
				$display("%0t: byte error: expected %h/%b/%b, actual %h/%b/%b",
					$time, exp_b.data, exp_b.item_last, exp_b.stream_last, d, il, sl);
				errors++;
			end
		endfunction
	endclass

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;  // [31:0] coeff_bits
	logic        s_tlast;  // stream_end
	logic        m_tvalid;
	logic        m_tready;
	logic [7:0]  m_tdata;  // [7:0] out_byte
	logic        m_tlast;  // stream_last
	logic [0:0]  m_tuser;  // [0] item_last

	zrle_byte_scoreboard sb = new();
	int  tx_gap_max = 8;
	int  rx_gap_max = 8;
	bit  rx_hold_armed = 1'b0;
	int  cycle_count = 0;

	zero_run_length_encoder_unit #(
		.RUN_MAX(FULL_RUN)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("zero_run_length_encoder_unit: mismatch");
			$finish;
		end
	end

	// Output side: a random stall before each byte, and once a long hold-off
	// so that the block backs up into its input.
	initial begin
		int stall;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			stall = $urandom_range(0, rx_gap_max);
			if (rx_hold_armed) begin
				rx_hold_armed = 1'b0;
				stall = HOLD_CYCLES;
			end
			repeat (stall) @(negedge clk) m_tready <= 1'b0;
			@(negedge clk) m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			sb.check_byte(m_tdata, m_tuser[0], m_tlast);
		end
	end

	task automatic send_coeff(logic [31:0] w, logic last);
		int gap;
		gap = $urandom_range(0, tx_gap_max);
		repeat (gap) @(negedge clk) s_tvalid <= 1'b0;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tdata  <= w;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		sb.note_coeff(w, last);
	endtask

	// Zero words that only extend a run give no output, so after the last
	// byte the block may still hold work: also wait out DRAIN_CYCLES.
	task automatic settle();
		@(negedge clk) s_tvalid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_mode(bit mode);
		settle();
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= mode;
		@(negedge clk) cfg_we <= 1'b0;
		sb.set_mode(mode);
	endtask

	function automatic logic [31:0] random_coeff();
		case ($urandom_range(0, 9))
			0: return POS_ZERO;
			1: return NEG_ZERO;
			2: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom_range(1, 32'h7F_FFFF))};
			3: return 32'($urandom_range(1, 255));
			4: return {$urandom_range(0, 1) == 1, 31'd1};
			default: return $urandom;
		endcase
	endfunction

	function automatic logic random_end();
		return $urandom_range(0, 6) == 0;
	endfunction

	// Mostly runs of zeros closed by a word, with stream ends at random.
	task automatic run_random(int n_items);
		int sent;
		int run_len;
		sent = 0;
		while (sent < n_items) begin
			run_len = $urandom_range(0, 6);
			for (int i = 0; i < run_len && sent < n_items; i++) begin
				send_coeff($urandom_range(0, 1) ? NEG_ZERO : POS_ZERO, random_end());
				sent++;
			end
			if (sent < n_items) begin
				send_coeff(random_coeff(), random_end());
				sent++;
			end
		end
	endtask

	initial begin
		arst_n    = 1'b0;
		cfg_we    = 1'b0;
		cfg_wdata = MODE_RLE;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tlast   = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk) arst_n <= 1'b1;

		// Encoding mode straight out of reset.
		send_coeff(32'h3F80_0000, 1'b0);
		send_coeff(POS_ZERO, 1'b0);
		send_coeff(NEG_ZERO, 1'b0);
		send_coeff(32'h0000_0001, 1'b0);
		send_coeff(32'hFFFF_FFFF, 1'b1);
		send_coeff(32'h7FC0_0000, 1'b0);
		send_coeff(POS_ZERO, 1'b0);
		send_coeff(NEG_ZERO, 1'b0);
		send_coeff(POS_ZERO, 1'b0);
		send_coeff(NEG_ZERO, 1'b1);
		send_coeff(32'h8000_0001, 1'b0);
		send_coeff(POS_ZERO, 1'b0);
		send_coeff(32'h7F80_0000, 1'b1);
		send_coeff(POS_ZERO, 1'b1);
		// Leave a run open across the switch to raw mode.
		send_coeff(POS_ZERO, 1'b0);
		send_coeff(NEG_ZERO, 1'b0);
		write_mode(MODE_RAW);
		send_coeff(32'hDEAD_BEEF, 1'b0);
		send_coeff(POS_ZERO, 1'b0);
		send_coeff(NEG_ZERO, 1'b0);
		send_coeff(32'hFFFF_FFFF, 1'b1);
		send_coeff(POS_ZERO, 1'b1);

		write_mode(MODE_RLE);
		tx_gap_max    = 8;
		rx_gap_max    = 8;
		rx_hold_armed = 1'b1;
		run_random(PHASE_ITEMS);
		write_mode(MODE_RAW);
		tx_gap_max = 0;
		rx_gap_max = 0;
		run_random(PHASE_ITEMS);
		write_mode(MODE_RLE);
		tx_gap_max = 0;
		rx_gap_max = 8;
		run_random(PHASE_ITEMS);
		write_mode(MODE_RAW);
		tx_gap_max = 8;
		rx_gap_max = 2;
		run_random(PHASE_ITEMS / 2);
		write_mode(MODE_RLE);
		run_random(PHASE_ITEMS / 2);

		settle();
		if (sb.errors == 0 && sb.pending() == 0)
			$display("zero_run_length_encoder_unit: match");
		else
			$display("zero_run_length_encoder_unit: mismatch");
		$finish;
	end

endmodule

>>> files.f
src/zrle_pkg.sv
src/zrle_front.sv
src/zrle_serial.sv
src/zero_run_length_encoder_unit.sv
src/zrle_checker.sv
dv/zero_run_length_encoder_unit_test.sv
